// ----- rtl/two_level_cache_hit_miss_model_defines.svh -----
// Assertion macros for the two-level cache tag model.
// Included by modules that carry concurrent assertions.
`ifndef TWO_LEVEL_CACHE_HIT_MISS_MODEL_DEFINES_SVH
`define TWO_LEVEL_CACHE_HIT_MISS_MODEL_DEFINES_SVH
`ifndef SYNTHESIS
`define TLC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TLC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/tlc_pkg.sv -----
// Shared constants and types for the two-level cache tag model.
// No dependencies.
package tlc_pkg;
  localparam int L1_SETS = 256;
  localparam int L1_WAYS = 8;
  localparam int L2_SETS = 1024;
  localparam int L2_WAYS = 16;
  localparam int ADDR_BITS = 32;
  localparam int L1_SB = $clog2(L1_SETS);
  localparam int L2_SB = $clog2(L2_SETS);
  localparam int L1_WB = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int L2_WB = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int L1_WCB = $clog2(L1_WAYS + 1);
  localparam int L2_WCB = $clog2(L2_WAYS + 1);

  typedef enum logic [2:0] {
    ST_NONE = 3'd0, ST_RH = 3'd1, ST_RM = 3'd2, ST_WH = 3'd3, ST_WM = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_L1_OFF = 3'd0, CFG_L1_IDX = 3'd1, CFG_L1_WAYS = 3'd2,
    CFG_L2_OFF = 3'd3, CFG_L2_IDX = 3'd4, CFG_L2_WAYS = 3'd5
  } cfg_idx_t;

  // one L1/L2 line: valid, dirty, tag
  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic [ADDR_BITS-1:0] tag;
  } line_t;
endpackage

// ----- rtl/tlc_stream_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on tlc_pkg.
interface tlc_req_if import tlc_pkg::*; ();
  logic valid;
  logic ready;
  logic func;
  logic [ADDR_BITS-1:0] addr;
  modport source (output valid, func, addr, input ready);
  modport sink (input valid, func, addr, output ready);
endinterface

interface tlc_rsp_if import tlc_pkg::*; ();
  logic valid;
  logic ready;
  logic [2:0] l1_status;
  logic [2:0] l2_status;
  logic l1_victim_dirty;
  modport source (output valid, l1_status, l2_status, l1_victim_dirty, input ready);
  modport sink (input valid, l1_status, l2_status, l1_victim_dirty, output ready);
endinterface

// ----- rtl/two_level_cache_hit_miss_model.sv -----
// Top level of the two-level cache tag model: config, sequencer, tag memories.
// Depends on tlc_pkg, tlc_stream_if and the defines header.
//
// channel | dir | handshake   | payload
// in      | in  | valid/ready | func, addr
// out     | out | valid/ready | l1_status, l2_status, l1_victim_dirty
// cfg     | in  | write enable| cfg_index, cfg_wdata
//
// A request runs S_RD1 and S_CMP1 on an L1 hit, and also S_RD2 and S_CMP2 on an L1 miss: set reads from the
// L1 and L2 line memories (each memory reads a whole set row per cycle), then
// write-back of the row.
// After reset a clearing pass in S_CLR sweeps every set of both memories; no
// request is taken meanwhile. A result waiting in the output register holds
// the next request in S_OUT until the result is taken.
`include "two_level_cache_hit_miss_model_defines.svh"
module two_level_cache_hit_miss_model
  import tlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tlc_req_if.sink     in_req,
  tlc_rsp_if.source   out_rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);
  typedef enum logic [6:0] {
    S_CLR = 7'b0000001, S_IDLE = 7'b0000010, S_RD1 = 7'b0000100,
    S_CMP1 = 7'b0001000, S_RD2 = 7'b0010000, S_CMP2 = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;

  typedef line_t [L1_WAYS-1:0] l1_row_t;
  typedef line_t [L2_WAYS-1:0] l2_row_t;

  l1_row_t l1_mem [L1_SETS];
  l2_row_t l2_mem [L2_SETS];
  logic [L1_WB-1:0] l1_ptr_mem [L1_SETS];
  logic [L2_WB-1:0] l2_ptr_mem [L2_SETS];

  logic [2:0] l1_ob_r, l2_ob_r;
  logic [3:0] l1_ib_r, l2_ib_r;
  logic [3:0] l1_w_r;
  logic [4:0] l2_w_r;

  state_t state_r, state_nxt;
  logic [L2_SB:0] clr_r;
  logic func_r;
  logic [L1_SB-1:0] s1_r;
  logic [L2_SB-1:0] s2_r;
  logic [ADDR_BITS-1:0] t1_r, t2_r;
  l1_row_t row1_r;
  l2_row_t row2_r;
  logic [L1_WB-1:0] p1_r;
  logic [L2_WB-1:0] p2_r;
  logic [2:0] st1_r, st2_r;
  logic vd_r, ovalid_r;
  logic [2:0] o_st1_r, o_st2_r;
  logic o_vd_r;
  logic [6:0] out_word;
  logic out_load;

  // address split
  function automatic logic [3:0] clamp_ib(input logic [3:0] ib, input int lim);
    clamp_ib = (int'(ib) > lim) ? 4'(lim) : ib;
  endfunction

  logic [3:0] ib1, ib2;
  logic [ADDR_BITS-1:0] sh1, sh2, t1, t2, m1, m2;
  logic [L1_SB-1:0] s1;
  logic [L2_SB-1:0] s2;
  always_comb begin
    ib1 = clamp_ib(l1_ib_r, L1_SB);
    ib2 = clamp_ib(l2_ib_r, L2_SB);
    sh1 = in_req.addr >> l1_ob_r;
    sh2 = in_req.addr >> l2_ob_r;
    m1 = (ADDR_BITS'(1) << ib1) - ADDR_BITS'(1);
    m2 = (ADDR_BITS'(1) << ib2) - ADDR_BITS'(1);
    s1 = L1_SB'(sh1 & m1);
    s2 = L2_SB'(sh2 & m2);
    t1 = sh1 >> ib1;
    t2 = sh2 >> ib2;
  end

  logic [L1_WCB-1:0] w1;
  logic [L2_WCB-1:0] w2;
  always_comb begin
    if (l1_w_r == 4'd0) w1 = L1_WCB'(1);
    else if (int'(l1_w_r) > L1_WAYS) w1 = L1_WCB'(L1_WAYS);
    else w1 = L1_WCB'(l1_w_r);
    if (l2_w_r == 5'd0) w2 = L2_WCB'(1);
    else if (int'(l2_w_r) > L2_WAYS) w2 = L2_WCB'(L2_WAYS);
    else w2 = L2_WCB'(l2_w_r);
  end

  // hit search over the registered rows
  logic h1, h2;
  logic [L1_WB-1:0] hw1, v1, v1n;
  logic [L2_WB-1:0] hw2, v2, v2n;
  always_comb begin
    h1 = 1'b0; hw1 = '0;
    for (int w = L1_WAYS - 1; w >= 0; w--) begin
      if (w < int'(w1) && row1_r[w].valid && row1_r[w].tag == t1_r) begin
        h1 = 1'b1; hw1 = L1_WB'(w);
      end
    end
    h2 = 1'b0; hw2 = '0;
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (w < int'(w2) && row2_r[w].valid && row2_r[w].tag == t2_r) begin
        h2 = 1'b1; hw2 = L2_WB'(w);
      end
    end
    v1 = (L1_WCB'(p1_r) < w1) ? p1_r : '0;
    v1n = (L1_WCB'(v1) + L1_WCB'(1) >= w1) ? '0 : L1_WB'(L1_WCB'(v1) + L1_WCB'(1));
    v2 = (L2_WCB'(p2_r) < w2) ? p2_r : '0;
    v2n = (L2_WCB'(v2) + L2_WCB'(1) >= w2) ? '0 : L2_WB'(L2_WCB'(v2) + L2_WCB'(1));
  end

  assign out_load = (state_r == S_OUT) && (!ovalid_r || out_rsp.ready);
  assign out_word = {o_st1_r, o_st2_r, o_vd_r};

  assign in_req.ready = (state_r == S_IDLE);
  assign out_rsp.valid = ovalid_r;
  assign out_rsp.l1_status = o_st1_r;
  assign out_rsp.l2_status = o_st2_r;
  assign out_rsp.l1_victim_dirty = o_vd_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_r == (L2_SB+1)'(L2_SETS - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_req.valid) state_nxt = S_RD1;
      S_RD1:  state_nxt = S_CMP1;
      S_CMP1: state_nxt = h1 ? S_OUT : S_RD2;
      S_RD2:  state_nxt = S_CMP2;
      S_CMP2: state_nxt = S_OUT;
      S_OUT:  if (!ovalid_r || out_rsp.ready) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      ovalid_r <= 1'b0;
      l1_ob_r <= 3'd3; l1_ib_r <= 4'd6; l1_w_r <= 4'd4;
      l2_ob_r <= 3'd3; l2_ib_r <= 4'd8; l2_w_r <= 5'd8;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (cfg_we) begin
        case (cfg_index)
          CFG_L1_OFF:  l1_ob_r <= cfg_wdata[2:0];
          CFG_L1_IDX:  l1_ib_r <= cfg_wdata[3:0];
          CFG_L1_WAYS: l1_w_r <= cfg_wdata[3:0];
          CFG_L2_OFF:  l2_ob_r <= cfg_wdata[2:0];
          CFG_L2_IDX:  l2_ib_r <= cfg_wdata[3:0];
          CFG_L2_WAYS: l2_w_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (out_load) ovalid_r <= 1'b1;
      else if (out_rsp.ready) ovalid_r <= 1'b0;
    end
  end

  // datapath and memories
  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      if (clr_r < (L2_SB+1)'(L1_SETS)) begin
        l1_mem[L1_SB'(clr_r)] <= '0;
        l1_ptr_mem[L1_SB'(clr_r)] <= '0;
      end
      l2_mem[L2_SB'(clr_r)] <= '0;
      l2_ptr_mem[L2_SB'(clr_r)] <= '0;
    end
    if (state_r == S_IDLE && in_req.valid) begin
      func_r <= in_req.func;
      s1_r <= s1; s2_r <= s2; t1_r <= t1; t2_r <= t2;
    end
    if (state_r == S_RD1 || state_r == S_RD2) begin
      row1_r <= l1_mem[s1_r];
      p1_r <= l1_ptr_mem[s1_r];
      row2_r <= l2_mem[s2_r];
      p2_r <= l2_ptr_mem[s2_r];
    end
    if (state_r == S_CMP1) begin
      vd_r <= 1'b0; st2_r <= ST_NONE;
      if (h1) begin
        st1_r <= func_r ? ST_WH : ST_RH;
        if (func_r) l1_mem[s1_r][hw1].dirty <= 1'b1;
      end else begin
        st1_r <= func_r ? ST_WM : ST_RM;
      end
    end
    if (state_r == S_CMP2) begin
      if (h2) begin
        st2_r <= func_r ? ST_WH : ST_RH;
        if (func_r) l2_mem[s2_r][hw2].dirty <= 1'b1;
      end else begin
        st2_r <= func_r ? ST_WM : ST_RM;
        if (!func_r) begin
          l2_mem[s2_r][v2] <= '{valid: 1'b1, dirty: 1'b0, tag: t2_r};
          l2_ptr_mem[s2_r] <= v2n;
        end
      end
      if (!func_r) begin
        vd_r <= row1_r[v1].valid && row1_r[v1].dirty;
        l1_mem[s1_r][v1] <= '{valid: 1'b1, dirty: 1'b0, tag: t1_r};
        l1_ptr_mem[s1_r] <= v1n;
      end
    end
    if (out_load) begin
      o_st1_r <= st1_r;
      o_st2_r <= st2_r;
      o_vd_r <= vd_r;
    end
  end

  `TLC_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_req.ready, state_r == S_IDLE)
  `TLC_ASSERT_NEXT(a_hit_no_l2, clk, rst_n, state_r == S_CMP1 && h1, st2_r == ST_NONE)
  `TLC_ASSERT_NEXT(a_miss_goes_l2, clk, rst_n, state_r == S_CMP1 && !h1, state_r == S_RD2)
  `TLC_ASSERT_IMPL(a_no_accept_clr, clk, rst_n, state_r == S_CLR, !in_req.ready)
  `TLC_ASSERT_NEXT(a_out_hold, clk, rst_n, ovalid_r && !out_rsp.ready, ovalid_r && $stable(out_word))
endmodule

// ----- bench/two_level_cache_hit_miss_model_tb.sv -----
// Self-checking bench for the two-level cache tag model: drives requests, config writes.
// Keeps its own tag/valid/dirty/fill-pointer copy and checks every result in order.
// Depends on tlc_pkg, tlc_stream_if and the top level two_level_cache_hit_miss_model.
module two_level_cache_hit_miss_model_tb;
  import tlc_pkg::*;

  typedef struct {
    status_t l1;
    status_t l2;
    bit      vd;
  } access_status_t;

  class cache_scoreboard;
    logic [31:0] l1_tag [L1_SETS*L1_WAYS];
    bit          l1_vld [L1_SETS*L1_WAYS];
    bit          l1_drt [L1_SETS*L1_WAYS];
    int          l1_ptr [L1_SETS];
    logic [31:0] l2_tag [L2_SETS*L2_WAYS];
    bit          l2_vld [L2_SETS*L2_WAYS];
    bit          l2_drt [L2_SETS*L2_WAYS];
    int          l2_ptr [L2_SETS];
    int          l1_off, l1_idx, l1_nw, l2_off, l2_idx, l2_nw;
    access_status_t pending[$];
    int          mismatches, checked, l1_hits, l2_hits, dirty_evicts;

    function new();
      foreach (l1_vld[i]) begin
        l1_tag[i] = 0; l1_vld[i] = 0; l1_drt[i] = 0;
      end
      foreach (l2_vld[i]) begin
        l2_tag[i] = 0; l2_vld[i] = 0; l2_drt[i] = 0;
      end
      foreach (l1_ptr[i]) l1_ptr[i] = 0;
      foreach (l2_ptr[i]) l2_ptr[i] = 0;
      l1_off = 3; l1_idx = 6; l1_nw = 4; l2_off = 3; l2_idx = 8; l2_nw = 8;
      mismatches = 0; checked = 0; l1_hits = 0; l2_hits = 0; dirty_evicts = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [4:0] val);
      case (idx)
        CFG_L1_OFF:  l1_off = val & 7;
        CFG_L1_IDX:  l1_idx = val & 15;
        CFG_L1_WAYS: l1_nw = val & 15;
        CFG_L2_OFF:  l2_off = val & 7;
        CFG_L2_IDX:  l2_idx = val & 15;
        CFG_L2_WAYS: l2_nw = val & 31;
        default: ;
      endcase
    endfunction

    function void split(logic [31:0] a, int ob, int ibc, int lim,
                        output int set, output logic [31:0] tag);
      int ib;
      ib = (ibc > lim) ? lim : ibc;
      set = int'((a >> ob) & ((32'd1 << ib) - 1));
      tag = a >> (ob + ib);
    endfunction

    function int active_ways(int w, int maxw);
      if (w == 0) return 1;
      return (w > maxw) ? maxw : w;
    endfunction

    function int victim(ref int ptr, input int ways);
      int v;
      v = (ptr < ways) ? ptr : 0;
      ptr = (v + 1 >= ways) ? 0 : v + 1;
      return v;
    endfunction

    function void note_request(bit wr, logic [31:0] a);
      int s1, s2, b1, b2, w1, w2, h1, h2, v;
      logic [31:0] t1, t2;
      access_status_t e;
      w1 = active_ways(l1_nw, L1_WAYS);
      w2 = active_ways(l2_nw, L2_WAYS);
      split(a, l1_off, l1_idx, L1_SB, s1, t1);
      split(a, l2_off, l2_idx, L2_SB, s2, t2);
      b1 = s1 * L1_WAYS;
      b2 = s2 * L2_WAYS;
      h1 = -1;
      for (int w = w1 - 1; w >= 0; w--)
        if (l1_vld[b1+w] && l1_tag[b1+w] == t1) h1 = w;
      h2 = -1;
      for (int w = w2 - 1; w >= 0; w--)
        if (l2_vld[b2+w] && l2_tag[b2+w] == t2) h2 = w;
      e.l2 = ST_NONE;
      e.vd = 0;
      if (h1 >= 0) begin
        l1_hits++;
        e.l1 = wr ? ST_WH : ST_RH;
        if (wr) l1_drt[b1+h1] = 1;
      end else begin
        if (h2 >= 0) l2_hits++;
        if (!wr) begin
          e.l1 = ST_RM;
          if (h2 >= 0) e.l2 = ST_RH;
          else begin
            e.l2 = ST_RM;
            v = b2 + victim(l2_ptr[s2], w2);
            l2_tag[v] = t2; l2_vld[v] = 1; l2_drt[v] = 0;
          end
          v = b1 + victim(l1_ptr[s1], w1);
          e.vd = l1_vld[v] && l1_drt[v];
          if (e.vd) dirty_evicts++;
          l1_tag[v] = t1; l1_vld[v] = 1; l1_drt[v] = 0;
        end else begin
          e.l1 = ST_WM;
          if (h2 >= 0) begin
            e.l2 = ST_WH;
            l2_drt[b2+h2] = 1;
          end else e.l2 = ST_WM;
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic [2:0] l1, logic [2:0] l2, logic vd);
      access_status_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result l1=%0d l2=%0d vd=%0d", l1, l2, vd);
        return;
      end
      e = pending.pop_front();
      if (l1 !== e.l1 || l2 !== e.l2 || vd !== e.vd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: exp l1=%0d l2=%0d vd=%0d got l1=%0d l2=%0d vd=%0d",
                   checked, e.l1, e.l2, e.vd, l1, l2, vd);
      end
    endfunction
  endclass

  logic clk, rst_n, cfg_we;
  logic [2:0] cfg_index;
  logic [4:0] cfg_wdata;
  tlc_req_if req_if();
  tlc_rsp_if rsp_if();
  cache_scoreboard sb;
  bit no_idle, hold_go;
  int hold_left, quiet_cycles, sent;
  logic [31:0] pool [16];

  two_level_cache_hit_miss_model DUT (
    .clk(clk), .rst_n(rst_n), .in_req(req_if), .out_rsp(rsp_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    if (hold_go && hold_left == 0) begin
      hold_left <= 400;
      hold_go = 0;
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (no_idle) rsp_if.ready <= 1'b1;
    else rsp_if.ready <= ($urandom_range(99) >= 33);
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready)
      sb.check_result(rsp_if.l1_status, rsp_if.l2_status, rsp_if.l1_victim_dirty);
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("watchdog expired with %0d results pending", sb.pending.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_request(bit wr, logic [31:0] a);
    int gap;
    gap = (!no_idle && $urandom_range(99) < 33) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.func <= wr;
    req_if.addr <= a;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(wr, a);
    sent++;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_config(int v0, int v1, int v2, int v3, int v4, int v5);
    int vals[6];
    vals = '{v0, v1, v2, v3, v4, v5};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_wdata <= vals[i][4:0];
      @(posedge clk);
      sb.write_reg(i[2:0], vals[i][4:0]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    logic [31:0] a;
    foreach (pool[i]) pool[i] = $urandom();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) a = pool[$urandom_range(15)] + $urandom_range(7);
      else a = $urandom();
      send_request($urandom_range(1), a);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    req_if.valid = 1'b0; req_if.func = 1'b0; req_if.addr = '0;
    rsp_if.ready = 1'b0;
    no_idle = 0; hold_go = 0; hold_left = 0; quiet_cycles = 0; sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_config(3, 6, 4, 3, 8, 8);

    // directed: extremes, hits, misses, dirty victim, write to L2 only
    send_request(0, 32'h0);
    send_request(0, 32'h0);
    send_request(1, 32'h0);
    send_request(0, 32'hFFFF_FFFF);
    send_request(1, 32'hFFFF_FFFF);
    for (int k = 1; k <= 4; k++) send_request(0, k * 512);
    send_request(1, 32'h0);
    send_request(0, 32'h0);
    send_request(1, 32'h1234_5678);
    send_request(1, 32'hAAAA_5555);
    send_request(0, 32'h5555_AAAA);
    drain();

    write_config(0, 0, 1, 0, 0, 1);
    random_phase(250);
    drain();
    write_config(7, 15, 15, 7, 15, 31);
    no_idle = 1;
    random_phase(200);
    no_idle = 0;
    hold_go = 1;
    random_phase(250);
    drain();
    write_config(2, 3, 0, 4, 5, 0);
    random_phase(250);
    drain();
    write_config(1, 2, 8, 2, 4, 16);
    random_phase(200);
    drain();
    // shrink ways so old fill pointers are out of range
    write_config(1, 2, 2, 2, 4, 3);
    random_phase(200);
    drain();
    cfg_we <= 1'b1; cfg_index <= 3'd6; cfg_wdata <= 5'd31;
    @(posedge clk);
    cfg_index <= 3'd7; cfg_wdata <= 5'd0;
    @(posedge clk);
    cfg_we <= 1'b0;
    write_config($urandom_range(31), $urandom_range(31), $urandom_range(31),
                 $urandom_range(31), $urandom_range(31), $urandom_range(31));
    random_phase(300);
    drain();

    $display("sent %0d requests, checked %0d results over 7 cache geometries", sent, sb.checked);
    $display("L1 hits %0d, L2 hits %0d, dirty L1 evictions %0d", sb.l1_hits, sb.l2_hits,
             sb.dirty_evicts);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ----- two_level_cache_hit_miss_model.f -----
+incdir+rtl
rtl/tlc_pkg.sv
rtl/tlc_stream_if.sv
rtl/two_level_cache_hit_miss_model.sv
bench/two_level_cache_hit_miss_model_tb.sv
